FILE: rtl/core/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// Shared types and constants of the nearest-point target table.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int COORD_W          = 13;
    localparam int OP_W             = 2;
    localparam int SQ_W             = 2 * COORD_W;
    localparam int DIST_W           = SQ_W + 1;
    localparam int SLOT_COUNT_DEF   = 16;

    // Operation codes; code 3 is unused and performs no operation.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_FIND   = 2'd2
    } t_op;

    // Control of the shared squaring unit.
    typedef struct packed {
        logic sq_x;    // square the x difference into the product register
        logic sq_y;    // move x term to the accumulator, square the y difference
    } t_dist_ctl;

endpackage

FILE: rtl/core/npt_if.sv
// ----------------------------------------------------------------------------
// npt_in_if / npt_out_if
// Valid/ready channels for operations into the table and results out of it.
// ----------------------------------------------------------------------------
interface npt_in_if;
    import npt_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;

    modport source (output valid, operation, pos_x, pos_y, input ready);
    modport sink   (input valid, operation, pos_x, pos_y, output ready);
endinterface

interface npt_out_if;
    import npt_pkg::*;

    logic               valid;
    logic               ready;
    logic               ok;
    logic [COORD_W-1:0] nearest_x;
    logic [COORD_W-1:0] nearest_y;
    logic               target_present;

    modport source (output valid, ok, nearest_x, nearest_y, target_present, input ready);
    modport sink   (input valid, ok, nearest_x, nearest_y, target_present, output ready);
endinterface

FILE: rtl/core/nearest_point_target_table.sv
// ----------------------------------------------------------------------------
// nearest_point_target_table
// Table of point slots with insert, remove-target and find-nearest operations.
//
//   channel  dir  payload                                          transaction
//   i_in     in   operation, pos_x, pos_y                          one operation
//   o_out    out  ok, nearest_x, nearest_y, target_present         one result
//
// Insert and remove scan the slot flags one slot per cycle and stop at the
// first empty slot (insert) or target slot (remove), or at the table end.
// Find scans every slot: each occupied slot needs one RAM read and two
// passes through the shared squaring unit.
// Reset clears the slot flags at once; no clearing pass runs over the RAM.
// The input is ready only while the sequencer is idle; a result waits in the
// output register, and the next operation cannot finish until it is taken.
// ----------------------------------------------------------------------------
module nearest_point_target_table #(
    parameter int SLOT_COUNT = npt_pkg::SLOT_COUNT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    npt_in_if.sink       i_in,
    npt_out_if.source    o_out
);
    import npt_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_SQX    = 5'b00100,
        S_SQY    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [OP_W-1:0]     r_op, n_op;
    logic [COORD_W-1:0]  r_px, n_px;
    logic [COORD_W-1:0]  r_py, n_py;
    logic [SLOT_COUNT-1:0] r_occ, n_occ;
    logic [SLOT_COUNT-1:0] r_target, n_target;
    logic [CW-1:0]       r_count, n_count;
    logic                r_ok, n_ok;
    logic                r_pend, n_pend;
    logic                r_found, n_found;
    logic [IW-1:0]       r_cand, n_cand;
    logic [IW-1:0]       r_best_idx, n_best_idx;
    logic [DIST_W-1:0]   r_best_d, n_best_d;
    logic [COORD_W-1:0]  r_best_x, n_best_x;
    logic [COORD_W-1:0]  r_best_y, n_best_y;
    logic                r_out_valid, n_out_valid;
    logic                r_out_ok, n_out_ok;
    logic [COORD_W-1:0]  r_out_x, n_out_x;
    logic [COORD_W-1:0]  r_out_y, n_out_y;
    logic                r_out_tp, n_out_tp;

    logic [IW-1:0]        idx_lo;
    logic                 at_end;
    logic                 find_hit;
    logic                 ram_we;
    logic                 ram_re;
    logic [2*COORD_W-1:0] ram_rdata;
    logic [COORD_W-1:0]   rd_x;
    logic [COORD_W-1:0]   rd_y;
    t_dist_ctl            dist_ctl;
    logic [DIST_W-1:0]    sq_dist;

    assign idx_lo   = r_idx[IW-1:0];
    assign at_end   = (r_idx == CW'(SLOT_COUNT));
    assign find_hit = (r_op == OP_FIND) && r_found;
    assign rd_x     = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_y     = ram_rdata[COORD_W-1:0];

    npt_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (SLOT_COUNT)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_lo),
        .i_wdata ({r_px, r_py}),
        .i_re    (ram_re),
        .i_raddr (idx_lo),
        .o_rdata (ram_rdata)
    );

    npt_dist u_dist (
        .i_clk  (i_clk),
        .i_ctl  (dist_ctl),
        .i_qx   (r_px),
        .i_qy   (r_py),
        .i_sx   (rd_x),
        .i_sy   (rd_y),
        .o_dist (sq_dist)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_op        = r_op;
        n_px        = r_px;
        n_py        = r_py;
        n_occ       = r_occ;
        n_target    = r_target;
        n_count     = r_count;
        n_ok        = r_ok;
        n_pend      = r_pend;
        n_found     = r_found;
        n_cand      = r_cand;
        n_best_idx  = r_best_idx;
        n_best_d    = r_best_d;
        n_best_x    = r_best_x;
        n_best_y    = r_best_y;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_tp    = r_out_tp;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        dist_ctl    = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.operation;
                    n_px    = i_in.pos_x;
                    n_py    = i_in.pos_y;
                    n_idx   = '0;
                    n_ok    = 1'b0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                unique case (r_op)
                    OP_INSERT: begin
                        if (at_end) begin
                            n_state = S_FINISH;
                        end else if (!r_occ[idx_lo]) begin
                            ram_we        = 1'b1;
                            n_occ[idx_lo] = 1'b1;
                            n_ok          = 1'b1;
                            n_state       = S_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (at_end) begin
                            n_state = S_FINISH;
                        end else if (r_target[idx_lo]) begin
                            n_occ[idx_lo]    = 1'b0;
                            n_target[idx_lo] = 1'b0;
                            n_count          = r_count - 1'b1;
                            n_ok             = 1'b1;
                            n_state          = S_FINISH;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    OP_FIND: begin
                        // The previous candidate's distance is compared while
                        // the next slot is being looked at.
                        if (r_pend) begin
                            n_pend = 1'b0;
                            if (!r_found || (sq_dist < r_best_d)) begin
                                n_found    = 1'b1;
                                n_best_d   = sq_dist;
                                n_best_idx = r_cand;
                                n_best_x   = rd_x;
                                n_best_y   = rd_y;
                            end
                        end
                        if (at_end) begin
                            n_state = S_FINISH;
                        end else if (r_occ[idx_lo]) begin
                            ram_re  = 1'b1;
                            n_cand  = idx_lo;
                            n_idx   = r_idx + 1'b1;
                            n_state = S_SQX;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SQX: begin
                dist_ctl.sq_x = 1'b1;
                n_state       = S_SQY;
            end
            S_SQY: begin
                dist_ctl.sq_y = 1'b1;
                n_pend        = 1'b1;
                n_state       = S_SCAN;
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = (r_op == OP_FIND) ? r_found : r_ok;
                    n_out_x     = find_hit ? r_best_x : '0;
                    n_out_y     = find_hit ? r_best_y : '0;
                    n_out_tp    = (r_count != '0) || find_hit;
                    if (find_hit) begin
                        n_target[r_best_idx] = 1'b1;
                        if (!r_target[r_best_idx]) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_target    <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_target    <= n_target;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_op       <= n_op;
        r_px       <= n_px;
        r_py       <= n_py;
        r_ok       <= n_ok;
        r_found    <= n_found;
        r_cand     <= n_cand;
        r_best_idx <= n_best_idx;
        r_best_d   <= n_best_d;
        r_best_x   <= n_best_x;
        r_best_y   <= n_best_y;
        r_out_ok   <= n_out_ok;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_tp   <= n_out_tp;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.ok             = r_out_ok;
    assign o_out.nearest_x      = r_out_x;
    assign o_out.nearest_y      = r_out_y;
    assign o_out.target_present = r_out_tp;

    // The target count tracks the target flags exactly.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_target) == r_count)
        else $error("target count differs from target flags");

    // Every target slot is also occupied.
    a_target_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_target & ~r_occ) == '0)
        else $error("target flag set on an empty slot");

    // A pending distance compare exists only while scanning.
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("distance compare pending outside the scan");

    // After a transaction is taken the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input ready right after a transaction");

endmodule

FILE: rtl/core/npt_ram.sv
// ----------------------------------------------------------------------------
// npt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/npt_dist.sv
// ----------------------------------------------------------------------------
// npt_dist
// Shared squaring unit: squares |dx| and then |dy| and presents their sum
// as the squared distance.
// ----------------------------------------------------------------------------
module npt_dist (
    input  logic                                i_clk,
    input  npt_pkg::t_dist_ctl                  i_ctl,
    input  logic [npt_pkg::COORD_W-1:0]         i_qx,
    input  logic [npt_pkg::COORD_W-1:0]         i_qy,
    input  logic [npt_pkg::COORD_W-1:0]         i_sx,
    input  logic [npt_pkg::COORD_W-1:0]         i_sy,
    output logic [npt_pkg::DIST_W-1:0]          o_dist
);
    import npt_pkg::*;

    logic [COORD_W-1:0] opa;
    logic [COORD_W-1:0] opb;
    logic [COORD_W-1:0] diff;
    logic [SQ_W-1:0]    sq;
    logic [SQ_W-1:0]    r_prod;
    logic [SQ_W-1:0]    r_acc;

    // One operand pair per cycle goes through the single multiplier.
    assign opa  = i_ctl.sq_y ? i_qy : i_qx;
    assign opb  = i_ctl.sq_y ? i_sy : i_sx;
    assign diff = (opa >= opb) ? (opa - opb) : (opb - opa);
    assign sq   = SQ_W'(diff) * SQ_W'(diff);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sq_x) begin
            r_prod <= sq;
        end else if (i_ctl.sq_y) begin
            r_acc  <= r_prod;
            r_prod <= sq;
        end
    end

    assign o_dist = DIST_W'(r_acc) + DIST_W'(r_prod);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest-point target table. Operations go in
// over the input channel with random gaps, results come back under random
// back-pressure, and a scoreboard that keeps its own copy of the slot table
// predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
    import npt_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int OP_TOTAL = 1450;
    localparam int IDLE_PCT = 37;
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        SLOT_EMPTY  = 2'd0,
        SLOT_POINT  = 2'd1,
        SLOT_TARGET = 2'd2
    } t_slot_kind;

    typedef struct packed {
        logic               ok;
        logic [COORD_W-1:0] nearest_x;
        logic [COORD_W-1:0] nearest_y;
        logic               target_present;
    } t_table_result;

    class target_table_scoreboard;
        t_slot_kind         kind [SLOTS];
        logic [COORD_W-1:0] slot_x [SLOTS];
        logic [COORD_W-1:0] slot_y [SLOTS];
        t_table_result      expected_results [$];
        int unsigned        errors;

        function new();
            foreach (kind[i]) begin
                kind[i]   = SLOT_EMPTY;
                slot_x[i] = '0;
                slot_y[i] = '0;
            end
            errors = 0;
        endfunction

        function int occupied();
            int n;
            n = 0;
            foreach (kind[i]) if (kind[i] != SLOT_EMPTY) n++;
            return n;
        endfunction

        function bit has_target();
            foreach (kind[i]) if (kind[i] == SLOT_TARGET) return 1'b1;
            return 1'b0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Applies one operation to the shadow table and returns its result.
        function t_table_result table_outcome(logic [OP_W-1:0] op,
                                              logic [COORD_W-1:0] px,
                                              logic [COORD_W-1:0] py);
            t_table_result     r;
            bit                found;
            int                best;
            logic [DIST_W-1:0] dx, dy, d, best_d;
            r      = '0;
            found  = 1'b0;
            best   = 0;
            best_d = '0;
            case (op)
                OP_INSERT: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (kind[i] == SLOT_EMPTY) begin
                            kind[i]   = SLOT_POINT;
                            slot_x[i] = px;
                            slot_y[i] = py;
                            r.ok      = 1'b1;
                            break;
                        end
                    end
                end
                OP_REMOVE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (kind[i] == SLOT_TARGET) begin
                            kind[i] = SLOT_EMPTY;
                            r.ok    = 1'b1;
                            break;
                        end
                    end
                end
                OP_FIND: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (kind[i] == SLOT_EMPTY) continue;
                        dx = (px >= slot_x[i]) ? px - slot_x[i] : slot_x[i] - px;
                        dy = (py >= slot_y[i]) ? py - slot_y[i] : slot_y[i] - py;
                        d  = dx * dx + dy * dy;
                        // Strict compare keeps the lowest index on a tie.
                        if (!found || d < best_d) begin
                            found  = 1'b1;
                            best_d = d;
                            best   = i;
                        end
                    end
                    if (found) begin
                        kind[best]  = SLOT_TARGET;
                        r.ok        = 1'b1;
                        r.nearest_x = slot_x[best];
                        r.nearest_y = slot_y[best];
                    end
                end
                default: ;
            endcase
            r.target_present = has_target();
            return r;
        endfunction

        function void note_op(logic [OP_W-1:0] op, logic [COORD_W-1:0] px,
                              logic [COORD_W-1:0] py);
            expected_results.push_back(table_outcome(op, px, py));
        endfunction

        function void check_result(t_table_result got);
            t_table_result exp;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: ok=%0b x=%0d y=%0d tp=%0b",
                             $realtime, got.ok, got.nearest_x, got.nearest_y,
                             got.target_present);
                return;
            end
            exp = expected_results.pop_front();
            if (got.ok !== exp.ok || got.nearest_x !== exp.nearest_x ||
                got.nearest_y !== exp.nearest_y ||
                got.target_present !== exp.target_present) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch ok %0b/%0b x %0d/%0d y %0d/%0d tp %0b/%0b (exp/act)",
                             $realtime, exp.ok, got.ok, exp.nearest_x, got.nearest_x,
                             exp.nearest_y, got.nearest_y, exp.target_present,
                             got.target_present);
            end
        endfunction

        function void report_leftovers();
            if (expected_results.size() != 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0d expected results never arrived", expected_results.size());
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on = 1'b1;

    npt_in_if  in_if ();
    npt_out_if out_if ();

    target_table_scoreboard sb = new();

    nearest_point_target_table #(
        .SLOT_COUNT (SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        out_if.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result('{out_if.ok, out_if.nearest_x, out_if.nearest_y,
                              out_if.target_present});
    end

    // Holds valid high across back-to-back transactions; it only drops
    // during a gap.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] px,
                           input logic [COORD_W-1:0] py);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.pos_x     <= px;
        in_if.pos_y     <= py;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_op(op, px, py);
    endtask

    task automatic wait_results_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Mixes corner values, a tight cluster for ties, exact copies of stored
    // points, and uniform values.
    task automatic pick_position(output logic [COORD_W-1:0] px,
                                 output logic [COORD_W-1:0] py);
        int sel, pick, n;
        sel = $urandom_range(99);
        n   = sb.occupied();
        px  = COORD_W'($urandom_range(COORD_MAX));
        py  = COORD_W'($urandom_range(COORD_MAX));
        if (sel < 15) begin
            px = $urandom_range(1) ? COORD_MAX : '0;
            py = $urandom_range(1) ? COORD_MAX : '0;
        end else if (sel < 40) begin
            px = COORD_W'(4093 + $urandom_range(6));
            py = COORD_W'(4093 + $urandom_range(6));
        end else if (sel < 50 && n > 0) begin
            pick = $urandom_range(n - 1);
            for (int i = 0; i < SLOTS; i++) begin
                if (sb.kind[i] != SLOT_EMPTY) begin
                    if (pick == 0) begin
                        px = sb.slot_x[i];
                        py = sb.slot_y[i];
                    end
                    pick--;
                end
            end
        end
    endtask

    initial begin
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] px, py;
        bit                 filling;
        int                 sel;
        filling         = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     <= 1'b0;
        in_if.operation <= OP_INSERT;
        in_if.pos_x     <= '0;
        in_if.pos_y     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, no target, unused code, corners, ties, full.
        send_op(OP_FIND, COORD_MAX, COORD_MAX);
        send_op(OP_REMOVE, '0, '0);
        send_op(OP_NONE, COORD_MAX, COORD_MAX);
        send_op(OP_INSERT, '0, '0);
        send_op(OP_INSERT, COORD_MAX, COORD_MAX);
        send_op(OP_FIND, COORD_MAX, COORD_MAX);
        send_op(OP_FIND, COORD_MAX, COORD_MAX);
        send_op(OP_FIND, '0, COORD_MAX);
        send_op(OP_INSERT, 13'd4096, 13'd4096);
        send_op(OP_INSERT, 13'd4096, 13'd4096);
        for (int i = 0; i < 12; i++)
            send_op(OP_INSERT, COORD_W'(i * 600 + 5), COORD_W'(8191 - i * 600));
        send_op(OP_INSERT, 13'd1234, 13'd4321);
        send_op(OP_FIND, 13'd4096, 13'd4096);
        send_op(OP_REMOVE, '0, '0);
        send_op(OP_REMOVE, '0, '0);

        for (int n = 26; n < OP_TOTAL; n++) begin
            idle_on = !(n >= 500 && n < 800);
            if (n % 250 == 0) wait_results_drained();
            // Alternate between filling the table and draining it through
            // find/remove pairs, so both the full and empty cases recur.
            if (n % 40 == 0) filling = !filling;
            sel = $urandom_range(99);
            if (sel < 3)
                op = OP_NONE;
            else if (filling)
                op = (sel < 58) ? OP_INSERT : (sel < 83) ? OP_FIND : OP_REMOVE;
            else
                op = (sel < 13) ? OP_INSERT : (sel < 48) ? OP_FIND : OP_REMOVE;
            pick_position(px, py);
            send_op(op, px, py);
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.errors == 0)
            $display("** nearest_point_target_table: PASSED **");
        else
            $display("** nearest_point_target_table: FAILED **");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("** nearest_point_target_table: FAILED **");
        $finish;
    end

endmodule
